// ===== hdl/flcc_pkg.sv =====
`default_nettype none
package flcc_pkg;

    // input item
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] pointer_x;
        logic signed [31:0] pointer_y;
        logic [5:0]         held_keys;
        logic [15:0]        delta_time;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } t_out_item;

    // configuration register indexes
    localparam logic [1:0] CFG_SENS_X = 2'd0;
    localparam logic [1:0] CFG_SENS_Y = 2'd1;
    localparam logic [1:0] CFG_SPEED  = 2'd2;

    localparam logic [15:0] SENS_RESET  = 16'd410;
    localparam logic [15:0] SPEED_RESET = 16'd1024;

    // item opcodes
    localparam logic OPC_POINTER = 1'b0;
    localparam logic OPC_TICK    = 1'b1;

    // datapath commands
    localparam logic [4:0] OP_NONE        = 5'd0;
    localparam logic [4:0] OP_LOAD        = 5'd1;
    localparam logic [4:0] OP_MUL_X       = 5'd2;
    localparam logic [4:0] OP_MUL_Y       = 5'd3;
    localparam logic [4:0] OP_PITCH       = 5'd4;
    localparam logic [4:0] OP_WRAP_STEP   = 5'd5;
    localparam logic [4:0] OP_WRAP_DONE   = 5'd6;
    localparam logic [4:0] OP_CORD_LD_YAW = 5'd7;
    localparam logic [4:0] OP_CORD_LD_PIT = 5'd8;
    localparam logic [4:0] OP_CORD_STEP   = 5'd9;
    localparam logic [4:0] OP_CORD_SV_YAW = 5'd10;
    localparam logic [4:0] OP_CORD_SV_PIT = 5'd11;
    localparam logic [4:0] OP_VEC_MUL     = 5'd12;
    localparam logic [4:0] OP_VEC_SAVE    = 5'd13;
    localparam logic [4:0] OP_SINGLE      = 5'd14;
    localparam logic [4:0] OP_STEP_MUL    = 5'd15;
    localparam logic [4:0] OP_MOVE_MUL    = 5'd16;
    localparam logic [4:0] OP_MOVE_ADD    = 5'd17;
    localparam logic [4:0] OP_PUBLISH     = 5'd18;

    typedef struct packed {
        logic [4:0] op;
        logic [4:0] idx;
        logic [2:0] key;
        logic [1:0] comp;
    } t_dp_cmd;

    typedef struct packed {
        logic       is_tick;
        logic [5:0] keys;
    } t_dp_status;

    // loop lengths
    localparam int CORDIC_STEPS = 23;
    localparam int WRAP_STEPS   = 14;
    localparam int KEY_COUNT    = 6;
    localparam int VEC_PRODUCTS = 4;

    // angles in Q16.16 degrees
    localparam logic signed [31:0] DEG_89  = 32'sd5832704;
    localparam logic signed [31:0] DEG_90  = 32'sd5898240;
    localparam logic signed [31:0] DEG_180 = 32'sd11796480;
    localparam logic signed [39:0] DEG_360 = 40'sd23592960;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [15:0] UNIT_Q14  = 16'sd16384;

    localparam logic signed [31:0] EYE_X_RESET = 32'sd0;
    localparam logic signed [31:0] EYE_Y_RESET = 32'sd131072;
    localparam logic signed [31:0] EYE_Z_RESET = -32'sd524288;

    // arctangent per CORDIC step, Q16.16 degrees
    function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
        logic signed [31:0] a;
        unique case (i)
            5'd0:    a = 32'sd2949120;
            5'd1:    a = 32'sd1740967;
            5'd2:    a = 32'sd919879;
            5'd3:    a = 32'sd466945;
            5'd4:    a = 32'sd234379;
            5'd5:    a = 32'sd117304;
            5'd6:    a = 32'sd58666;
            5'd7:    a = 32'sd29335;
            5'd8:    a = 32'sd14668;
            5'd9:    a = 32'sd7334;
            5'd10:   a = 32'sd3667;
            5'd11:   a = 32'sd1833;
            5'd12:   a = 32'sd917;
            5'd13:   a = 32'sd458;
            5'd14:   a = 32'sd229;
            5'd15:   a = 32'sd115;
            5'd16:   a = 32'sd57;
            5'd17:   a = 32'sd29;
            5'd18:   a = 32'sd14;
            5'd19:   a = 32'sd7;
            5'd20:   a = 32'sd4;
            5'd21:   a = 32'sd2;
            5'd22:   a = 32'sd1;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/flcc_dpath.sv =====
`default_nettype none
module flcc_dpath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire flcc_pkg::t_dp_cmd     i_cmd,
    output flcc_pkg::t_dp_status       o_status,
    input  wire flcc_pkg::t_in_item    i_in_data,
    output flcc_pkg::t_out_item        o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [15:0]           i_cfg_data
);
    import flcc_pkg::*;

    // configuration
    logic [15:0] r_sens_x, r_sens_y, r_speed;

    // captured item
    logic               r_op;
    logic signed [31:0] r_px, r_py;
    logic [5:0]         r_keys;
    logic [15:0]        r_dt;

    // camera state
    logic signed [31:0] r_last_x, r_last_y;
    logic               r_seen;
    logic signed [31:0] r_yaw, r_pitch;
    logic signed [31:0] r_eye [3];
    logic signed [15:0] r_front [3];
    logic signed [15:0] r_right_x, r_right_z;
    logic signed [15:0] r_up [3];

    // working registers
    logic signed [66:0] r_prod;
    logic signed [39:0] r_wrap;
    logic signed [33:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic               r_neg;
    logic signed [33:0] r_cos_y, r_sin_y, r_cos_p, r_sin_p;
    logic [31:0]        r_step;
    t_out_item          r_out;

    // rounding by 2^s, then clamp to a unit in Q2.14
    function automatic logic signed [15:0] to_q14(input logic signed [66:0] v,
                                                   input logic [5:0] s);
        logic signed [66:0] r;
        r = (v + (67'sd1 <<< (s - 6'd1))) >>> s;
        if (r > 67'(UNIT_Q14)) begin
            return UNIT_Q14;
        end else if (r < -67'(UNIT_Q14)) begin
            return -UNIT_Q14;
        end
        return 16'(r);
    endfunction

    // pointer deltas, zero on the first sample
    logic signed [32:0] dx, dy;
    assign dx = r_seen ? 33'(r_px) - 33'(r_last_x) : 33'sd0;
    assign dy = r_seen ? 33'(r_last_y) - 33'(r_py) : 33'sd0;

    // angle offset from the held product
    logic signed [66:0] off_wide;
    logic signed [39:0] off;
    assign off_wide = (r_prod + 67'sd2048) >>> 12;
    assign off      = 40'(off_wide);

    // selected movement vector component
    logic signed [15:0] mv;
    always_comb begin
        mv = 16'sd0;
        priority case (i_cmd.key)
            3'd0, 3'd1: begin
                unique case (i_cmd.comp)
                    2'd0:    mv = r_front[0];
                    2'd1:    mv = r_front[1];
                    2'd2:    mv = r_front[2];
                    default: mv = 16'sd0;
                endcase
            end
            3'd2, 3'd3: begin
                unique case (i_cmd.comp)
                    2'd0:    mv = r_right_x;
                    2'd2:    mv = r_right_z;
                    default: mv = 16'sd0;
                endcase
            end
            default: begin
                unique case (i_cmd.comp)
                    2'd0:    mv = r_up[0];
                    2'd1:    mv = r_up[1];
                    2'd2:    mv = r_up[2];
                    default: mv = 16'sd0;
                endcase
            end
        endcase
    end

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] mul_p;
    always_comb begin
        mul_a = 34'sd0;
        mul_b = 33'sd0;
        unique case (i_cmd.op)
            OP_MUL_X: begin
                mul_a = 34'(dx);
                mul_b = $signed({17'b0, r_sens_x});
            end
            OP_MUL_Y: begin
                mul_a = 34'(dy);
                mul_b = $signed({17'b0, r_sens_y});
            end
            OP_VEC_MUL: begin
                mul_a = i_cmd.idx[0] ? r_sin_y : r_cos_y;
                mul_b = i_cmd.idx[1] ? 33'(r_sin_p) : 33'(r_cos_p);
            end
            OP_STEP_MUL: begin
                mul_a = $signed({18'b0, r_speed});
                mul_b = $signed({17'b0, r_dt});
            end
            OP_MOVE_MUL: begin
                mul_a = 34'(mv);
                mul_b = $signed({1'b0, r_step});
            end
            default: begin
                mul_a = 34'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end
    assign mul_p = 67'(mul_a) * 67'(mul_b);

    // yaw wrap, pitch clamp, fold, CORDIC and movement terms
    logic signed [39:0] wrap_m, wrap_fix, pit_sum;
    logic signed [33:0] sh_x, sh_y;
    logic signed [31:0] at;
    logic signed [33:0] mv_d, mv_e;
    logic               mv_pos;
    logic [1:0]         cfg_sel;
    always_comb begin
        wrap_m   = DEG_360 <<< i_cmd.idx[3:0];
        wrap_fix = (r_wrap < 40'sd0) ? r_wrap + DEG_360 : r_wrap;
        pit_sum  = 40'(r_pitch) + off;
        sh_x     = r_cx >>> i_cmd.idx;
        sh_y     = r_cy >>> i_cmd.idx;
        at       = atan_deg(i_cmd.idx);
        mv_d     = 34'((r_prod + 67'sd2097152) >>> 22);
        mv_pos   = (i_cmd.key == 3'd0) || (i_cmd.key == 3'd3) || (i_cmd.key == 3'd4);
        mv_e     = 34'sd0;
        unique case (i_cmd.comp)
            2'd0:    mv_e = 34'(r_eye[0]);
            2'd1:    mv_e = 34'(r_eye[1]);
            2'd2:    mv_e = 34'(r_eye[2]);
            default: mv_e = 34'sd0;
        endcase
        mv_e    = mv_pos ? mv_e + mv_d : mv_e - mv_d;
        cfg_sel = i_cfg_index;
    end

    // saturated eye component
    logic signed [31:0] mv_sat;
    always_comb begin
        if (mv_e > 34'sd2147483647) begin
            mv_sat = 32'sh7FFFFFFF;
        end else if (mv_e < -34'sd2147483648) begin
            mv_sat = 32'sh80000000;
        end else begin
            mv_sat = 32'(mv_e);
        end
    end

    // state with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens_x   <= SENS_RESET;
            r_sens_y   <= SENS_RESET;
            r_speed    <= SPEED_RESET;
            r_last_x   <= 32'sd0;
            r_last_y   <= 32'sd0;
            r_seen     <= 1'b0;
            r_yaw      <= -DEG_90;
            r_pitch    <= 32'sd0;
            r_eye[0]   <= EYE_X_RESET;
            r_eye[1]   <= EYE_Y_RESET;
            r_eye[2]   <= EYE_Z_RESET;
            r_front[0] <= 16'sd0;
            r_front[1] <= 16'sd0;
            r_front[2] <= -UNIT_Q14;
            r_right_x  <= UNIT_Q14;
            r_right_z  <= 16'sd0;
            r_up[0]    <= 16'sd0;
            r_up[1]    <= UNIT_Q14;
            r_up[2]    <= 16'sd0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                unique case (cfg_sel)
                    CFG_SENS_X: r_sens_x <= i_cfg_data;
                    CFG_SENS_Y: r_sens_y <= i_cfg_data;
                    CFG_SPEED:  r_speed  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (i_cmd.op)
                OP_MUL_Y: begin
                    r_last_x <= r_px;
                    r_last_y <= r_py;
                    r_seen   <= 1'b1;
                end
                OP_PITCH: begin
                    if (pit_sum > 40'(DEG_89)) begin
                        r_pitch <= DEG_89;
                    end else if (pit_sum < -40'(DEG_89)) begin
                        r_pitch <= -DEG_89;
                    end else begin
                        r_pitch <= 32'(pit_sum);
                    end
                end
                OP_WRAP_DONE: r_yaw <= 32'(wrap_fix - 40'(DEG_180));
                OP_VEC_SAVE: begin
                    unique case (i_cmd.idx[1:0])
                        2'd0: r_front[0] <= to_q14(r_prod, 6'd46);
                        2'd1: r_front[2] <= to_q14(r_prod, 6'd46);
                        2'd2: r_up[0]    <= to_q14(-r_prod, 6'd46);
                        2'd3: r_up[2]    <= to_q14(-r_prod, 6'd46);
                    endcase
                end
                OP_SINGLE: begin
                    r_front[1] <= to_q14(67'(r_sin_p), 6'd16);
                    r_right_x  <= to_q14(-67'(r_sin_y), 6'd16);
                    r_right_z  <= to_q14(67'(r_cos_y), 6'd16);
                    r_up[1]    <= to_q14(67'(r_cos_p), 6'd16);
                end
                OP_MOVE_ADD: begin
                    unique case (i_cmd.comp)
                        2'd0:    r_eye[0] <= mv_sat;
                        2'd1:    r_eye[1] <= mv_sat;
                        2'd2:    r_eye[2] <= mv_sat;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // working registers, no reset
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_op   <= i_in_data.opcode;
                r_px   <= i_in_data.pointer_x;
                r_py   <= i_in_data.pointer_y;
                r_keys <= i_in_data.held_keys;
                r_dt   <= i_in_data.delta_time;
            end
            OP_MUL_X: r_prod <= mul_p;
            OP_MUL_Y: begin
                r_prod <= mul_p;
                r_wrap <= 40'(r_yaw) + off + 40'(DEG_180);
            end
            OP_WRAP_STEP: begin
                if (r_wrap >= wrap_m) begin
                    r_wrap <= r_wrap - wrap_m;
                end else if (r_wrap < 40'sd0) begin
                    r_wrap <= r_wrap + wrap_m;
                end
            end
            OP_CORD_LD_YAW: begin
                r_cx <= CORDIC_X0;
                r_cy <= 34'sd0;
                if (r_yaw > DEG_90) begin
                    r_cz  <= r_yaw - DEG_180;
                    r_neg <= 1'b1;
                end else if (r_yaw < -DEG_90) begin
                    r_cz  <= r_yaw + DEG_180;
                    r_neg <= 1'b1;
                end else begin
                    r_cz  <= r_yaw;
                    r_neg <= 1'b0;
                end
            end
            OP_CORD_LD_PIT: begin
                r_cx  <= CORDIC_X0;
                r_cy  <= 34'sd0;
                r_cz  <= r_pitch;
                r_neg <= 1'b0;
            end
            OP_CORD_STEP: begin
                if (!r_cz[31]) begin
                    r_cx <= r_cx - sh_y;
                    r_cy <= r_cy + sh_x;
                    r_cz <= r_cz - at;
                end else begin
                    r_cx <= r_cx + sh_y;
                    r_cy <= r_cy - sh_x;
                    r_cz <= r_cz + at;
                end
            end
            OP_CORD_SV_YAW: begin
                r_cos_y <= r_neg ? -r_cx : r_cx;
                r_sin_y <= r_neg ? -r_cy : r_cy;
            end
            OP_CORD_SV_PIT: begin
                r_cos_p <= r_cx;
                r_sin_p <= r_cy;
            end
            OP_VEC_MUL:  r_prod <= mul_p;
            OP_STEP_MUL: r_step <= 32'(mul_p);
            OP_MOVE_MUL: r_prod <= mul_p;
            OP_PUBLISH: begin
                r_out.eye_x   <= r_eye[0];
                r_out.eye_y   <= r_eye[1];
                r_out.eye_z   <= r_eye[2];
                r_out.front_x <= r_front[0];
                r_out.front_y <= r_front[1];
                r_out.front_z <= r_front[2];
                r_out.right_x <= r_right_x;
                r_out.right_z <= r_right_z;
                r_out.up_x    <= r_up[0];
                r_out.up_y    <= r_up[1];
                r_out.up_z    <= r_up[2];
            end
            default: ;
        endcase
    end

    assign o_status.is_tick = (r_op == OPC_TICK);
    assign o_status.keys    = r_keys;
    assign o_out_data       = r_out;

endmodule
`default_nettype wire

// ===== hdl/flcc_ctrl.sv =====
`default_nettype none
module flcc_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output flcc_pkg::t_dp_cmd          o_cmd,
    input  wire flcc_pkg::t_dp_status  i_status
);
    import flcc_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_MULX   = 5'd2;
    localparam logic [4:0] S_MULY   = 5'd3;
    localparam logic [4:0] S_PITCH  = 5'd4;
    localparam logic [4:0] S_WRAP   = 5'd5;
    localparam logic [4:0] S_WRAPD  = 5'd6;
    localparam logic [4:0] S_CLY    = 5'd7;
    localparam logic [4:0] S_CSY    = 5'd8;
    localparam logic [4:0] S_SVY    = 5'd9;
    localparam logic [4:0] S_CLP    = 5'd10;
    localparam logic [4:0] S_CSP    = 5'd11;
    localparam logic [4:0] S_SVP    = 5'd12;
    localparam logic [4:0] S_VMUL   = 5'd13;
    localparam logic [4:0] S_VSAVE  = 5'd14;
    localparam logic [4:0] S_SINGLE = 5'd15;
    localparam logic [4:0] S_STEP   = 5'd16;
    localparam logic [4:0] S_SCAN   = 5'd17;
    localparam logic [4:0] S_MMUL   = 5'd18;
    localparam logic [4:0] S_MADD   = 5'd19;
    localparam logic [4:0] S_DONE   = 5'd20;

    localparam logic [4:0] CORD_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic [4:0] WRAP_TOP  = 5'(WRAP_STEPS - 1);
    localparam logic [4:0] VEC_LAST  = 5'(VEC_PRODUCTS - 1);
    localparam logic [2:0] KEY_END   = 3'(KEY_COUNT);

    logic [4:0] r_state, n_state;
    logic [4:0] r_idx, n_idx;
    logic [2:0] r_key, n_key;
    logic [1:0] r_comp, n_comp;
    logic       r_out_valid, n_out_valid;
    logic [4:0] op;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_key       = r_key;
        n_comp      = r_comp;
        op          = OP_NONE;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP:  n_state = i_status.is_tick ? S_STEP : S_MULX;
            S_MULX: begin
                op      = OP_MUL_X;
                n_state = S_MULY;
            end
            S_MULY: begin
                op      = OP_MUL_Y;
                n_state = S_PITCH;
            end
            S_PITCH: begin
                op      = OP_PITCH;
                n_idx   = WRAP_TOP;
                n_state = S_WRAP;
            end
            S_WRAP: begin
                op = OP_WRAP_STEP;
                if (r_idx == 5'd0) begin
                    n_state = S_WRAPD;
                end else begin
                    n_idx = r_idx - 5'd1;
                end
            end
            S_WRAPD: begin
                op      = OP_WRAP_DONE;
                n_state = S_CLY;
            end
            S_CLY: begin
                op      = OP_CORD_LD_YAW;
                n_idx   = 5'd0;
                n_state = S_CSY;
            end
            S_CSY: begin
                op    = OP_CORD_STEP;
                n_idx = r_idx + 5'd1;
                if (r_idx == CORD_LAST) begin
                    n_state = S_SVY;
                end
            end
            S_SVY: begin
                op      = OP_CORD_SV_YAW;
                n_state = S_CLP;
            end
            S_CLP: begin
                op      = OP_CORD_LD_PIT;
                n_idx   = 5'd0;
                n_state = S_CSP;
            end
            S_CSP: begin
                op    = OP_CORD_STEP;
                n_idx = r_idx + 5'd1;
                if (r_idx == CORD_LAST) begin
                    n_state = S_SVP;
                end
            end
            S_SVP: begin
                op      = OP_CORD_SV_PIT;
                n_idx   = 5'd0;
                n_state = S_VMUL;
            end
            S_VMUL: begin
                op      = OP_VEC_MUL;
                n_state = S_VSAVE;
            end
            S_VSAVE: begin
                op = OP_VEC_SAVE;
                if (r_idx == VEC_LAST) begin
                    n_state = S_SINGLE;
                end else begin
                    n_idx   = r_idx + 5'd1;
                    n_state = S_VMUL;
                end
            end
            S_SINGLE: begin
                op      = OP_SINGLE;
                n_state = S_DONE;
            end
            S_STEP: begin
                op      = OP_STEP_MUL;
                n_key   = 3'd0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_key >= KEY_END) begin
                    n_state = S_DONE;
                end else if (i_status.keys[r_key]) begin
                    n_comp  = 2'd0;
                    n_state = S_MMUL;
                end else begin
                    n_key = r_key + 3'd1;
                end
            end
            S_MMUL: begin
                op      = OP_MOVE_MUL;
                n_state = S_MADD;
            end
            S_MADD: begin
                op = OP_MOVE_ADD;
                if (r_comp == 2'd2) begin
                    n_key   = r_key + 3'd1;
                    n_state = S_SCAN;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = S_MMUL;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    op          = OP_PUBLISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= 5'd0;
            r_key       <= 3'd0;
            r_comp      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_key       <= n_key;
            r_comp      <= n_comp;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.op     = op;
    assign o_cmd.idx    = r_idx;
    assign o_cmd.key    = r_key;
    assign o_cmd.comp   = r_comp;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;

endmodule
`default_nettype wire

// ===== hdl/free_look_camera_controller_core.sv =====
// channel   handshake                  payload
// in        i_in_valid / o_in_ready    i_in_data   (pointer sample or movement tick)
// out       o_out_valid / i_out_ready  o_out_data  (eye, front, right, up)
// cfg       i_cfg_we                   i_cfg_index, i_cfg_data
//
// A pointer sample runs the yaw wrap and two 23-step CORDIC passes on one shared
// rotation unit, then four products on one multiplier.
// A movement tick scans each key bit in turn and, for each held key, does one multiply
// and one add per component. Reset is synchronous and restores the camera pose and registers.
// A finished result sits in the output register while the next item is taken;
// the block stalls at the end of that item until the output is free.
`default_nettype none
module free_look_camera_controller_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire flcc_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output flcc_pkg::t_out_item       o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);
    import flcc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer
    flcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // arithmetic and camera state
    flcc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import flcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    free_look_camera_controller_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // camera model state
    longint    cam_sens_x, cam_sens_y, cam_speed;
    longint    cam_last_x, cam_last_y;
    bit        cam_seen;
    longint    cam_yaw, cam_pitch;
    longint    cam_eye[3];
    longint    cam_front[3];
    longint    cam_right[2];
    longint    cam_up[3];
    t_out_item pose_queue[$];

    int  error_count;
    int  sent_count;
    int  recv_count;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  timed_out;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint atan_step(int i);
        longint tbl[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
        return tbl[i];
    endfunction

    // rotation-mode CORDIC over [-90, 90] degrees, results in Q30
    task automatic rotate_unit(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = 652032874;
        y = 0;
        z = ang;
        for (int i = 0; i < 23; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = x;
        s = y;
    endtask

    function automatic longint unit_q14(longint v, int s);
        return clip(round_shift(v, s), -16384, 16384);
    endfunction

    task automatic rebuild_basis();
        longint cy, sy, cp, sp;
        longint d90, d180;
        d90 = longint'(DEG_90);
        d180 = longint'(DEG_180);
        if (cam_yaw > d90 || cam_yaw < -d90) begin
            rotate_unit(cam_yaw > 0 ? cam_yaw - d180 : cam_yaw + d180, cy, sy);
            cy = -cy;
            sy = -sy;
        end else begin
            rotate_unit(cam_yaw, cy, sy);
        end
        rotate_unit(cam_pitch, cp, sp);
        cam_front[0] = unit_q14(cy * cp, 46);
        cam_front[1] = unit_q14(sp, 16);
        cam_front[2] = unit_q14(sy * cp, 46);
        cam_right[0] = unit_q14(-sy, 16);
        cam_right[1] = unit_q14(cy, 16);
        cam_up[0]    = unit_q14(-cy * sp, 46);
        cam_up[1]    = unit_q14(cp, 16);
        cam_up[2]    = unit_q14(-sy * sp, 46);
    endtask

    task automatic slide_eye(input longint step, input longint vx, input longint vy,
                             input longint vz, input bit negate);
        longint v[3];
        longint d;
        v[0] = vx; v[1] = vy; v[2] = vz;
        for (int k = 0; k < 3; k++) begin
            d = round_shift(step * v[k], 22);
            cam_eye[k] = clip(negate ? cam_eye[k] - d : cam_eye[k] + d,
                              -64'sd2147483648, 64'sd2147483647);
        end
    endtask

    task automatic reset_camera();
        cam_sens_x = SENS_RESET;
        cam_sens_y = SENS_RESET;
        cam_speed  = SPEED_RESET;
        cam_last_x = 0;
        cam_last_y = 0;
        cam_seen   = 1'b0;
        cam_yaw    = -longint'(DEG_90);
        cam_pitch  = 0;
        cam_eye    = '{EYE_X_RESET, EYE_Y_RESET, EYE_Z_RESET};
        cam_front  = '{0, 0, -16384};
        cam_right  = '{16384, 0};
        cam_up     = '{0, 16384, 0};
    endtask

    // advance the camera by one item and queue the resulting pose
    task automatic predict_pose(input t_in_item it);
        longint px, py, dx, dy, r, step, m360, d180, d89;
        t_out_item p;
        m360 = longint'(DEG_360);
        d180 = longint'(DEG_180);
        d89  = longint'(DEG_89);
        if (it.opcode == OPC_POINTER) begin
            px = longint'(it.pointer_x);
            py = longint'(it.pointer_y);
            if (!cam_seen) begin
                cam_last_x = px;
                cam_last_y = py;
                cam_seen = 1'b1;
            end
            dx = px - cam_last_x;
            dy = cam_last_y - py;
            cam_last_x = px;
            cam_last_y = py;
            r = (cam_yaw + round_shift(dx * cam_sens_x, 12) + d180) % m360;
            if (r < 0) r += m360;
            cam_yaw = r - d180;
            cam_pitch = clip(cam_pitch + round_shift(dy * cam_sens_y, 12), -d89, d89);
            rebuild_basis();
        end else begin
            step = cam_speed * longint'(it.delta_time);
            if (it.held_keys[0]) slide_eye(step, cam_front[0], cam_front[1], cam_front[2], 0);
            if (it.held_keys[1]) slide_eye(step, cam_front[0], cam_front[1], cam_front[2], 1);
            if (it.held_keys[2]) slide_eye(step, cam_right[0], 0, cam_right[1], 1);
            if (it.held_keys[3]) slide_eye(step, cam_right[0], 0, cam_right[1], 0);
            if (it.held_keys[4]) slide_eye(step, cam_up[0], cam_up[1], cam_up[2], 0);
            if (it.held_keys[5]) slide_eye(step, cam_up[0], cam_up[1], cam_up[2], 1);
        end
        p.eye_x   = cam_eye[0][31:0];
        p.eye_y   = cam_eye[1][31:0];
        p.eye_z   = cam_eye[2][31:0];
        p.front_x = cam_front[0][15:0];
        p.front_y = cam_front[1][15:0];
        p.front_z = cam_front[2][15:0];
        p.right_x = cam_right[0][15:0];
        p.right_z = cam_right[1][15:0];
        p.up_x    = cam_up[0][15:0];
        p.up_y    = cam_up[1][15:0];
        p.up_z    = cam_up[2][15:0];
        pose_queue.push_back(p);
    endtask

    // send one item; blocks until the transfer, valid is left high for the next caller to drop or reuse
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_pose(it);
        sent_count++;
    endtask

    // register write while idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SENS_X: cam_sens_x = val;
            CFG_SENS_Y: cam_sens_y = val;
            CFG_SPEED:  cam_speed  = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pose_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_in_item make_pointer(logic signed [31:0] x, logic signed [31:0] y);
        t_in_item it;
        it.opcode    = OPC_POINTER;
        it.pointer_x = x;
        it.pointer_y = y;
        it.held_keys = 6'($urandom);
        it.delta_time = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_tick(logic [5:0] keys, logic [15:0] dt);
        t_in_item it;
        it.opcode     = OPC_TICK;
        it.pointer_x  = $urandom;
        it.pointer_y  = $urandom;
        it.held_keys  = keys;
        it.delta_time = dt;
        return it;
    endfunction

    // random mix: mostly modest pointer motion and ticks, some extreme jumps
    function automatic t_in_item random_item();
        int sel;
        logic signed [31:0] x, y;
        sel = $urandom_range(99);
        if (sel < 45) begin
            x = $signed(cam_last_x[31:0]) + $signed(32'($urandom_range(0, 2000000)) - 1000000);
            y = $signed(cam_last_y[31:0]) + $signed(32'($urandom_range(0, 2000000)) - 1000000);
            return make_pointer(x, y);
        end else if (sel < 52) begin
            return make_pointer($urandom, $urandom);
        end else if (sel < 95) begin
            return make_tick(6'($urandom), 16'($urandom_range(0, 4000)));
        end
        return make_tick(6'($urandom), 16'($urandom));
    endfunction

    // pose checker
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            recv_count++;
            if (pose_queue.size() == 0) begin
                $error("pose transfer with none expected");
                error_count++;
            end else begin
                e = pose_queue.pop_front();
                if (o_out_data.eye_x !== e.eye_x) begin
                    $error("eye_x exp %0d got %0d", e.eye_x, o_out_data.eye_x); error_count++;
                end
                if (o_out_data.eye_y !== e.eye_y) begin
                    $error("eye_y exp %0d got %0d", e.eye_y, o_out_data.eye_y); error_count++;
                end
                if (o_out_data.eye_z !== e.eye_z) begin
                    $error("eye_z exp %0d got %0d", e.eye_z, o_out_data.eye_z); error_count++;
                end
                if (o_out_data.front_x !== e.front_x) begin
                    $error("front_x exp %0d got %0d", e.front_x, o_out_data.front_x);
                    error_count++;
                end
                if (o_out_data.front_y !== e.front_y) begin
                    $error("front_y exp %0d got %0d", e.front_y, o_out_data.front_y);
                    error_count++;
                end
                if (o_out_data.front_z !== e.front_z) begin
                    $error("front_z exp %0d got %0d", e.front_z, o_out_data.front_z);
                    error_count++;
                end
                if (o_out_data.right_x !== e.right_x) begin
                    $error("right_x exp %0d got %0d", e.right_x, o_out_data.right_x);
                    error_count++;
                end
                if (o_out_data.right_z !== e.right_z) begin
                    $error("right_z exp %0d got %0d", e.right_z, o_out_data.right_z);
                    error_count++;
                end
                if (o_out_data.up_x !== e.up_x) begin
                    $error("up_x exp %0d got %0d", e.up_x, o_out_data.up_x); error_count++;
                end
                if (o_out_data.up_y !== e.up_y) begin
                    $error("up_y exp %0d got %0d", e.up_y, o_out_data.up_y); error_count++;
                end
                if (o_out_data.up_z !== e.up_z) begin
                    $error("up_z exp %0d got %0d", e.up_z, o_out_data.up_z); error_count++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("free_look_camera_controller_core verification failed");
            $finish;
        end
    end

    // reset pose, first sample, pitch clamp both ways, yaw wrap both ways
    task automatic test_pointer_directed();
        send_item(make_pointer(32'sd123456, -32'sd654321));
        send_item(make_pointer(32'sd123456, -32'sd654321));
        send_item(make_pointer(32'sd0, -32'sd2147483648));
        send_item(make_pointer(32'sd0, 32'sd2147483647));
        send_item(make_pointer(32'sd2147483647, 32'sd0));
        send_item(make_pointer(-32'sd2147483648, 32'sd1000));
        send_item(make_pointer(-32'sd2147483648 + 32'sd6553600, 32'sd0));
        send_item(make_pointer(32'sd40000000, -32'sd9000000));
        drain();
    endtask

    // every key, conflicting keys, time extremes
    task automatic test_tick_directed();
        for (int k = 0; k < 6; k++) send_item(make_tick(6'(1 << k), 16'hFFFF));
        send_item(make_tick(6'b000011, 16'd1000));
        send_item(make_tick(6'b111111, 16'hFFFF));
        send_item(make_tick(6'b000000, 16'hFFFF));
        send_item(make_tick(6'b101010, 16'd0));
        drain();
    endtask

    // eye saturation at the register extremes
    task automatic test_saturation();
        write_reg(CFG_SPEED, 16'hFFFF);
        for (int i = 0; i < 70; i++) send_item(make_tick(6'b010101, 16'hFFFF));
        for (int i = 0; i < 140; i++) send_item(make_tick(6'b101010, 16'hFFFF));
        drain();
        write_reg(CFG_SPEED, 16'd0);
        send_item(make_tick(6'b111111, 16'hFFFF));
        drain();
    endtask

    // random phases over register settings and idle profiles
    task automatic test_random();
        int sx[5] = '{0, 65535, 410, 1, 5000};
        int sy[5] = '{65535, 0, 410, 2000, 1};
        int sp[5] = '{0, 65535, 1024, 300, 20000};
        int idle_tbl[4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{35, 35}};
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_SENS_X, 16'(sx[ph % 5]));
            write_reg(CFG_SENS_Y, 16'(sy[ph % 5]));
            write_reg(CFG_SPEED, 16'(sp[ph % 5]));
            if (ph == 3) write_reg(2'd3, 16'($urandom));
            send_idle_pct  = idle_tbl[ph % 4][0];
            recv_stall_pct = idle_tbl[ph % 4][1];
            for (int i = 0; i < 170; i++) send_item(random_item());
            drain();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        error_count    = 0;
        sent_count     = 0;
        recv_count     = 0;
        idle_cycles    = 0;
        timed_out      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        reset_camera();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pointer_directed();
        test_tick_directed();
        test_saturation();
        test_random();
        drain();
        repeat (100) @(posedge i_clk);

        $display("covered %0d items (pointer samples and movement ticks), %0d poses checked,",
                 sent_count, recv_count);
        $display("register extremes, eye saturation and four handshake idle profiles");
        if (error_count == 0 && pose_queue.size() == 0) begin
            $display("free_look_camera_controller_core verification clean");
        end else begin
            if (pose_queue.size() != 0) $error("%0d poses never arrived", pose_queue.size());
            $display("free_look_camera_controller_core verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
